>>> design/wcm_pkg.sv
// ============================================================================
// wcm_pkg
// Shared types and constants of the weighted confusion-matrix metrics block.
// ============================================================================
package wcm_pkg;

    // Fixed field widths
    localparam int PROB_BITS    = 16;
    localparam int WEIGHT_BITS  = 16;
    localparam int FRAC_BITS    = PROB_BITS + 1;
    localparam int MISS_BITS    = 24;
    localparam int FLAG_BITS    = 4;
    localparam int NUM_RATIOS   = 4;

    // Defaults of the top-level parameters
    localparam int COUNT_BITS_DEF = 32;
    localparam int ITEM_BITS_DEF  = 24;

    // Threshold after reset: one half
    localparam logic [PROB_BITS-1:0] THRESH_RESET = PROB_BITS'(1) << (PROB_BITS - 1);

    // Input tdata layout, lowest bit up: probability, observed, weight
    localparam int IN_OBS_POS     = PROB_BITS;
    localparam int IN_WEIGHT_LSB  = PROB_BITS + 1;
    localparam int IN_USED_BITS   = PROB_BITS + 1 + WEIGHT_BITS;
    localparam int IN_TDATA_BITS  = ((IN_USED_BITS + 7) / 8) * 8;

    // Output tdata layout, lowest bit up:
    // sensitivity, specificity, ppv, npv, miss_rate, undefined_flags, overflow
    localparam int OUT_USED_BITS  = NUM_RATIOS * FRAC_BITS + MISS_BITS + FLAG_BITS + 1;
    localparam int OUT_TDATA_BITS = ((OUT_USED_BITS + 7) / 8) * 8;
    localparam int OUT_PAD_BITS   = OUT_TDATA_BITS - OUT_USED_BITS;

    // Largest fraction (exactly one)
    localparam logic [FRAC_BITS-1:0] FRAC_ONE = FRAC_BITS'(1) << PROB_BITS;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_START,
        ST_WAIT,
        ST_HOLD
    } t_state;

    // Division being worked on; ratio codes double as flag bit numbers
    typedef enum logic [2:0] {
        OP_SENS,
        OP_SPEC,
        OP_PPV,
        OP_NPV,
        OP_MISS
    } t_op;

    // Control from the sequencer to the accumulator
    typedef struct packed {
        logic take;   // an observation transaction is accepted
        logic clear;  // pass finished, return counters to zero
    } t_acc_ctl;

endpackage

>>> design/weighted_confusion_metrics.sv
// ============================================================================
// weighted_confusion_metrics
// Weighted confusion-matrix metrics of a binary classifier over one pass.
// ============================================================================
// Usage:
//   s_axis carries one observation per transaction (probability, observed
//   class, weight); s_axis_tlast marks the final observation of a pass.
//   Items that are not last produce no result and are taken one per cycle.
//   After the last item a sequencer runs five divisions in turn on one
//   shared bit-serial divider (sensitivity, specificity, PPV, NPV, miss
//   rate); one with a zero denominator skips the divider and yields zero.
//   The pass result is then written to the output register; s_axis is
//   not ready from the last item until that write.
//   The result sits in an output register: while it waits on m_axis_tready
//   the next pass may already accumulate; a second result waits until the
//   first one is taken. Counters clear when the result is registered.
//   The cfg channel writes the threshold (always ready); write it only
//   while the block is idle.
//   Reset (synchronous, active low) clears all counters, drops m_axis
//   valid and sets the threshold to one half.
// ============================================================================
module weighted_confusion_metrics #(
    parameter int COUNT_BITS = wcm_pkg::COUNT_BITS_DEF,
    parameter int ITEM_BITS  = wcm_pkg::ITEM_BITS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // Threshold write channel
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [wcm_pkg::PROB_BITS-1:0]        i_cfg_data,
    // Observations
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // tdata: probability[15:0], observed[16], weight[32:17], zero pad
    input  logic [wcm_pkg::IN_TDATA_BITS-1:0]    s_axis_tdata,
    input  logic                                 s_axis_tlast,
    // Pass results
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // tdata: sensitivity[16:0], specificity[33:17], positive_predictive[50:34],
    //        negative_predictive[67:51], miss_rate[91:68],
    //        undefined_flags[95:92], counter_overflow[96], zero pad
    output logic [wcm_pkg::OUT_TDATA_BITS-1:0]   m_axis_tdata
);

    localparam int PB       = wcm_pkg::PROB_BITS;
    localparam int FB       = wcm_pkg::FRAC_BITS;
    localparam int MB       = wcm_pkg::MISS_BITS;
    localparam int NUM_BITS = COUNT_BITS + 1;
    localparam int DEN_BITS = (NUM_BITS > ITEM_BITS) ? NUM_BITS : ITEM_BITS;
    localparam int DIV_BITS = NUM_BITS + PB;

    // Threshold register
    logic [PB-1:0] r_threshold;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= wcm_pkg::THRESH_RESET;
        end else if (i_cfg_valid) begin
            r_threshold <= i_cfg_data;
        end
    end

    assign o_cfg_ready = 1'b1;

    // Sequencer and datapath signals
    wcm_pkg::t_state   r_state, n_state;
    wcm_pkg::t_op      r_op, n_op;
    wcm_pkg::t_acc_ctl w_acc;
    logic              w_clear;

    logic [COUNT_BITS-1:0] w_tp, w_tn, w_fp, w_fn;
    logic [ITEM_BITS-1:0]  w_items;
    logic                  w_sat;

    logic [NUM_BITS-1:0]   w_num;
    logic [DEN_BITS-1:0]   w_den;
    logic                  w_div_start;
    logic                  w_div_done;
    logic [DIV_BITS-1:0]   w_div_q;

    logic                  w_in_take;
    logic                  w_res_we;
    logic                  w_res_zero;
    logic                  w_out_free;
    logic                  w_out_load;
    logic [MB-1:0]         w_miss_sat;

    logic [FB-1:0]                    r_frac [wcm_pkg::NUM_RATIOS];
    logic [MB-1:0]                    r_miss;
    logic [wcm_pkg::FLAG_BITS-1:0]    r_flags;
    logic                             r_out_valid;
    logic [wcm_pkg::OUT_TDATA_BITS-1:0] r_out_data;

    // Observations are taken only while idle
    assign s_axis_tready = (r_state == wcm_pkg::ST_IDLE);
    assign w_in_take  = s_axis_tvalid && s_axis_tready;
    assign w_out_free = !r_out_valid || m_axis_tready;
    assign w_acc      = '{take: w_in_take, clear: w_clear};

    // Counters
    wcm_accum #(
        .COUNT_BITS (COUNT_BITS),
        .ITEM_BITS  (ITEM_BITS)
    ) u_accum (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctl         (w_acc),
        .i_threshold   (r_threshold),
        .i_probability (s_axis_tdata[PB-1:0]),
        .i_observed    (s_axis_tdata[wcm_pkg::IN_OBS_POS]),
        .i_weight      (s_axis_tdata[wcm_pkg::IN_USED_BITS-1:wcm_pkg::IN_WEIGHT_LSB]),
        .o_tp          (w_tp),
        .o_tn          (w_tn),
        .o_fp          (w_fp),
        .o_fn          (w_fn),
        .o_items       (w_items),
        .o_sat         (w_sat)
    );

    // Shared divider
    wcm_div #(
        .NUM_BITS (NUM_BITS),
        .DEN_BITS (DEN_BITS)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_num),
        .i_den   (w_den),
        .o_done  (w_div_done),
        .o_quot  (w_div_q)
    );

    // Operand select for the current division
    always_comb begin
        w_num = '0;
        w_den = '0;
        case (r_op)
            wcm_pkg::OP_SENS: begin
                w_num = NUM_BITS'(w_tp);
                w_den = DEN_BITS'(NUM_BITS'(w_tp) + NUM_BITS'(w_fn));
            end
            wcm_pkg::OP_SPEC: begin
                w_num = NUM_BITS'(w_tn);
                w_den = DEN_BITS'(NUM_BITS'(w_tn) + NUM_BITS'(w_fp));
            end
            wcm_pkg::OP_PPV: begin
                w_num = NUM_BITS'(w_tp);
                w_den = DEN_BITS'(NUM_BITS'(w_tp) + NUM_BITS'(w_fp));
            end
            wcm_pkg::OP_NPV: begin
                w_num = NUM_BITS'(w_tn);
                w_den = DEN_BITS'(NUM_BITS'(w_tn) + NUM_BITS'(w_fn));
            end
            wcm_pkg::OP_MISS: begin
                w_num = NUM_BITS'(w_fp) + NUM_BITS'(w_fn);
                w_den = DEN_BITS'(w_items);
            end
            default: begin
                w_num = '0;
                w_den = '0;
            end
        endcase
    end

    // Miss rate clamps to the Q8.16 range
    assign w_miss_sat = (|w_div_q[DIV_BITS-1:MB]) ? '1 : w_div_q[MB-1:0];

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= wcm_pkg::ST_IDLE;
            r_op    <= wcm_pkg::OP_SENS;
        end else begin
            r_state <= n_state;
            r_op    <= n_op;
        end
    end

    // Next state and controls
    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        w_div_start = 1'b0;
        w_res_we    = 1'b0;
        w_res_zero  = 1'b0;
        w_out_load  = 1'b0;
        w_clear     = 1'b0;
        case (r_state)
            wcm_pkg::ST_IDLE: begin
                if (w_in_take && s_axis_tlast) begin
                    n_state = wcm_pkg::ST_START;
                    n_op    = wcm_pkg::OP_SENS;
                end
            end
            wcm_pkg::ST_START: begin
                if (w_den == '0) begin
                    w_res_we   = 1'b1;
                    w_res_zero = 1'b1;
                end else begin
                    w_div_start = 1'b1;
                    n_state     = wcm_pkg::ST_WAIT;
                end
            end
            wcm_pkg::ST_WAIT: begin
                if (w_div_done) begin
                    w_res_we = 1'b1;
                end
            end
            wcm_pkg::ST_HOLD: begin
                if (w_out_free) begin
                    w_out_load = 1'b1;
                    w_clear    = 1'b1;
                    n_state    = wcm_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = wcm_pkg::ST_IDLE;
            end
        endcase

        // Move on once a result is stored
        if (w_res_we) begin
            case (r_op)
                wcm_pkg::OP_SENS: begin
                    n_op    = wcm_pkg::OP_SPEC;
                    n_state = wcm_pkg::ST_START;
                end
                wcm_pkg::OP_SPEC: begin
                    n_op    = wcm_pkg::OP_PPV;
                    n_state = wcm_pkg::ST_START;
                end
                wcm_pkg::OP_PPV: begin
                    n_op    = wcm_pkg::OP_NPV;
                    n_state = wcm_pkg::ST_START;
                end
                wcm_pkg::OP_NPV: begin
                    n_op    = wcm_pkg::OP_MISS;
                    n_state = wcm_pkg::ST_START;
                end
                default: begin
                    n_state = wcm_pkg::ST_HOLD;
                end
            endcase
        end
    end

    // Zero-denominator flags, cleared at the start of each evaluation
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flags <= '0;
        end else if (r_state == wcm_pkg::ST_IDLE && w_in_take && s_axis_tlast) begin
            r_flags <= '0;
        end else if (w_res_we && w_res_zero && r_op != wcm_pkg::OP_MISS) begin
            r_flags[r_op[1:0]] <= 1'b1;
        end
    end

    // Result staging
    always_ff @(posedge i_clk) begin
        if (w_res_we) begin
            if (r_op == wcm_pkg::OP_MISS) begin
                r_miss <= w_res_zero ? '0 : w_miss_sat;
            end else begin
                r_frac[r_op[1:0]] <= w_res_zero ? '0 : w_div_q[FB-1:0];
            end
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out_data <= {{wcm_pkg::OUT_PAD_BITS{1'b0}}, w_sat, r_flags, r_miss,
                           r_frac[3], r_frac[2], r_frac[1], r_frac[0]};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    // Checks
    a_load_from_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(r_state) == wcm_pkg::ST_HOLD)
        else $error("result registered outside the hold state");

    a_div_done_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> r_state == wcm_pkg::ST_WAIT)
        else $error("divider finished while sequencer was not waiting");

    a_clear_after_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_out_load |=> (w_items == '0 && !w_sat))
        else $error("counters not cleared after the pass result");

    a_sens_flag_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tdata[FB*wcm_pkg::NUM_RATIOS + MB]) |->
            m_axis_tdata[FB-1:0] == '0)
        else $error("sensitivity nonzero with zero denominator");

    a_frac_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[FB-1:0] <= wcm_pkg::FRAC_ONE &&
                           m_axis_tdata[2*FB-1:FB] <= wcm_pkg::FRAC_ONE))
        else $error("fraction above one");

endmodule

>>> design/wcm_accum.sv
// ============================================================================
// wcm_accum
// Confusion counters: one compare and one shared saturating add per item.
// ============================================================================
module wcm_accum #(
    parameter int COUNT_BITS = wcm_pkg::COUNT_BITS_DEF,
    parameter int ITEM_BITS  = wcm_pkg::ITEM_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  wcm_pkg::t_acc_ctl                i_ctl,
    input  logic [wcm_pkg::PROB_BITS-1:0]    i_threshold,
    input  logic [wcm_pkg::PROB_BITS-1:0]    i_probability,
    input  logic                             i_observed,
    input  logic [wcm_pkg::WEIGHT_BITS-1:0]  i_weight,
    output logic [COUNT_BITS-1:0]            o_tp,
    output logic [COUNT_BITS-1:0]            o_tn,
    output logic [COUNT_BITS-1:0]            o_fp,
    output logic [COUNT_BITS-1:0]            o_fn,
    output logic [ITEM_BITS-1:0]             o_items,
    output logic                             o_sat
);

    logic [COUNT_BITS-1:0] r_tp, r_tn, r_fp, r_fn;
    logic [ITEM_BITS-1:0]  r_items;
    logic                  r_sat;

    logic                  w_pos;
    logic [COUNT_BITS-1:0] w_sel;
    logic [COUNT_BITS:0]   w_sum;
    logic                  w_full;
    logic [COUNT_BITS-1:0] w_new;

    // Classify and pick the counter that this item feeds
    always_comb begin
        w_pos = i_probability > i_threshold;
        case ({i_observed, w_pos})
            2'b11:   w_sel = r_tp;
            2'b10:   w_sel = r_fn;
            2'b01:   w_sel = r_fp;
            default: w_sel = r_tn;
        endcase
        w_sum  = {1'b0, w_sel} + (COUNT_BITS + 1)'(i_weight);
        w_full = w_sum[COUNT_BITS];
        w_new  = w_full ? '1 : w_sum[COUNT_BITS-1:0];
    end

    // Counter registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.clear) begin
            r_tp    <= '0;
            r_tn    <= '0;
            r_fp    <= '0;
            r_fn    <= '0;
            r_items <= '0;
            r_sat   <= 1'b0;
        end else if (i_ctl.take) begin
            case ({i_observed, w_pos})
                2'b11:   r_tp <= w_new;
                2'b10:   r_fn <= w_new;
                2'b01:   r_fp <= w_new;
                default: r_tn <= w_new;
            endcase
            if (w_full) begin
                r_sat <= 1'b1;
            end
            if (r_items != '1) begin
                r_items <= r_items + ITEM_BITS'(1);
            end
        end
    end

    assign o_tp    = r_tp;
    assign o_tn    = r_tn;
    assign o_fp    = r_fp;
    assign o_fn    = r_fn;
    assign o_items = r_items;
    assign o_sat   = r_sat;

endmodule

>>> design/wcm_div.sv
// ============================================================================
// wcm_div
// Shared restoring divider: floor(num * 2^PROB_BITS / den), one bit a cycle.
// ============================================================================
module wcm_div #(
    parameter int NUM_BITS = wcm_pkg::COUNT_BITS_DEF + 1,
    parameter int DEN_BITS = wcm_pkg::COUNT_BITS_DEF + 1
) (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  logic                                     i_start,
    input  logic [NUM_BITS-1:0]                      i_num,
    input  logic [DEN_BITS-1:0]                      i_den,
    output logic                                     o_done,
    output logic [NUM_BITS+wcm_pkg::PROB_BITS-1:0]   o_quot
);

    localparam int DIV_BITS = NUM_BITS + wcm_pkg::PROB_BITS;
    localparam int CNT_BITS = $clog2(DIV_BITS + 1);

    logic [DEN_BITS-1:0] r_den;
    logic [DEN_BITS-1:0] r_rem;
    logic [DIV_BITS-1:0] r_quo;   // dividend shifts out, quotient shifts in
    logic [CNT_BITS-1:0] r_cnt;
    logic                r_busy;
    logic                r_done;

    logic [DEN_BITS:0]   w_trial;
    logic [DEN_BITS:0]   w_diff;
    logic                w_ge;

    // One trial subtraction per step
    always_comb begin
        w_trial = {r_rem, r_quo[DIV_BITS-1]};
        w_diff  = w_trial - {1'b0, r_den};
        w_ge    = w_trial >= {1'b0, r_den};
    end

    // Step control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_BITS'(DIV_BITS);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_BITS'(1);
                if (r_cnt == CNT_BITS'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_den <= i_den;
            r_rem <= '0;
            r_quo <= {i_num, {wcm_pkg::PROB_BITS{1'b0}}};
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[DEN_BITS-1:0] : w_trial[DEN_BITS-1:0];
            r_quo <= {r_quo[DIV_BITS-2:0], w_ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quo;

endmodule

>>> test/wcm_checker.sv
`timescale 1ns / 1ps
// ============================================================================
// wcm_checker
// Watches the threshold, observation and result channels of the weighted
// confusion-matrix block, predicts every pass result and compares it field
// by field with what the block delivers.
// ============================================================================
module wcm_checker (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // Threshold write channel
    input  logic                                 i_cfg_valid,
    input  logic                                 i_cfg_ready,
    input  logic [wcm_pkg::PROB_BITS-1:0]        i_cfg_data,
    // Observation stream
    input  logic                                 i_obs_valid,
    input  logic                                 i_obs_ready,
    // data: probability, observed, weight, zero pad
    input  logic [wcm_pkg::IN_TDATA_BITS-1:0]    i_obs_data,
    input  logic                                 i_obs_last,
    // Result stream
    input  logic                                 i_res_valid,
    input  logic                                 i_res_ready,
    // data: sens, spec, ppv, npv, miss_rate, undefined_flags, overflow, pad
    input  logic [wcm_pkg::OUT_TDATA_BITS-1:0]   i_res_data,
    output int                                   o_mismatches,
    output int                                   o_pending,
    output int                                   o_checked
);

    localparam int PB      = wcm_pkg::PROB_BITS;
    localparam int WB      = wcm_pkg::WEIGHT_BITS;
    localparam int FB      = wcm_pkg::FRAC_BITS;
    localparam int MB      = wcm_pkg::MISS_BITS;
    localparam int NR      = wcm_pkg::NUM_RATIOS;
    localparam int COUNT_W = wcm_pkg::COUNT_BITS_DEF;
    localparam int ITEM_W  = wcm_pkg::ITEM_BITS_DEF;
    localparam bit [COUNT_W-1:0]   COUNT_TOP = '1;
    localparam bit [ITEM_W-1:0]    ITEM_TOP  = '1;
    localparam longint unsigned    MISS_TOP  = (64'd1 << MB) - 1;
    localparam int                 PRINT_CAP = 60;

    // One pass result, declared high field first so it overlays tdata
    typedef struct packed {
        logic                          overflow;
        logic [wcm_pkg::FLAG_BITS-1:0] undefined;
        logic [MB-1:0]                 miss_rate;
        logic [FB-1:0]                 npv;
        logic [FB-1:0]                 ppv;
        logic [FB-1:0]                 spec;
        logic [FB-1:0]                 sens;
    } t_metrics;

    // Predicted state of the current pass
    logic [PB-1:0]        thresh_reg;
    bit [COUNT_W-1:0]     tp_weight;
    bit [COUNT_W-1:0]     fn_weight;
    bit [COUNT_W-1:0]     fp_weight;
    bit [COUNT_W-1:0]     tn_weight;
    bit [ITEM_W-1:0]      item_total;
    bit                   saturated;

    t_metrics metrics_due[$];
    int       mismatches = 0;
    int       checked    = 0;

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        if (mismatches < PRINT_CAP)
            $display("%0t ns  result %0d: %s is %0d, predicted %0d",
                     $time, checked, what, got, want);
        mismatches++;
    endtask

    // Saturating add of one weight into a confusion counter
    function automatic bit [COUNT_W-1:0] add_weight(input bit [COUNT_W-1:0] acc,
                                                    input bit [WB-1:0] w);
        bit [COUNT_W:0] total;
        total = {1'b0, acc} + (COUNT_W + 1)'(w);
        if (total[COUNT_W]) begin
            saturated = 1'b1;
            return COUNT_TOP;
        end
        return total[COUNT_W-1:0];
    endfunction

    // floor(num * 2^PROB_BITS / den), held at top
    function automatic longint unsigned fraction_of(input longint unsigned num,
                                                    input longint unsigned den,
                                                    input longint unsigned top);
        longint unsigned q;
        q = (num << PB) / den;
        return (q > top) ? top : q;
    endfunction

    function automatic t_metrics pass_metrics();
        t_metrics             m;
        longint unsigned      num  [NR];
        longint unsigned      den  [NR];
        logic [FB-1:0]        frac [NR];
        m = '0;
        num[wcm_pkg::OP_SENS] = 64'(tp_weight);
        den[wcm_pkg::OP_SENS] = 64'(tp_weight) + 64'(fn_weight);
        num[wcm_pkg::OP_SPEC] = 64'(tn_weight);
        den[wcm_pkg::OP_SPEC] = 64'(tn_weight) + 64'(fp_weight);
        num[wcm_pkg::OP_PPV]  = 64'(tp_weight);
        den[wcm_pkg::OP_PPV]  = 64'(tp_weight) + 64'(fp_weight);
        num[wcm_pkg::OP_NPV]  = 64'(tn_weight);
        den[wcm_pkg::OP_NPV]  = 64'(tn_weight) + 64'(fn_weight);
        // a zero denominator gives 0 and raises that ratio's flag
        for (int r = 0; r < NR; r++) begin
            frac[r] = '0;
            if (den[r] == 0)
                m.undefined[r] = 1'b1;
            else
                frac[r] = FB'(fraction_of(num[r], den[r], 64'(wcm_pkg::FRAC_ONE)));
        end
        m.sens = frac[wcm_pkg::OP_SENS];
        m.spec = frac[wcm_pkg::OP_SPEC];
        m.ppv  = frac[wcm_pkg::OP_PPV];
        m.npv  = frac[wcm_pkg::OP_NPV];
        if (item_total != 0)
            m.miss_rate = MB'(fraction_of(64'(fp_weight) + 64'(fn_weight),
                                          64'(item_total), MISS_TOP));
        m.overflow = saturated;
        return m;
    endfunction

    function automatic void clear_pass();
        tp_weight  = '0;
        fn_weight  = '0;
        fp_weight  = '0;
        tn_weight  = '0;
        item_total = '0;
        saturated  = 1'b0;
    endfunction

    // Follow every transaction at the clock edge that completes it
    always @(posedge i_clk) begin : watch
        t_metrics                          got;
        t_metrics                          want;
        logic [wcm_pkg::OUT_PAD_BITS-1:0]  pad;
        logic [PB-1:0]                     prob;
        logic                              observed;
        logic [WB-1:0]                     weight;
        logic                              positive;
        if (!i_rst_n) begin
            clear_pass();
            thresh_reg = wcm_pkg::THRESH_RESET;
            metrics_due.delete();
        end else begin
            // result transaction: compare with the oldest prediction
            if (i_res_valid && i_res_ready) begin
                got = i_res_data[wcm_pkg::OUT_USED_BITS-1:0];
                pad = i_res_data[wcm_pkg::OUT_TDATA_BITS-1:wcm_pkg::OUT_USED_BITS];
                if (metrics_due.size() == 0) begin
                    report_mismatch("result with no pass pending", 64'd1, 64'd0);
                end else begin
                    want = metrics_due.pop_front();
                    if (got.sens !== want.sens)
                        report_mismatch("sensitivity", 64'(got.sens), 64'(want.sens));
                    if (got.spec !== want.spec)
                        report_mismatch("specificity", 64'(got.spec), 64'(want.spec));
                    if (got.ppv !== want.ppv)
                        report_mismatch("positive_predictive", 64'(got.ppv),
                                        64'(want.ppv));
                    if (got.npv !== want.npv)
                        report_mismatch("negative_predictive", 64'(got.npv),
                                        64'(want.npv));
                    if (got.miss_rate !== want.miss_rate)
                        report_mismatch("miss_rate", 64'(got.miss_rate),
                                        64'(want.miss_rate));
                    if (got.undefined !== want.undefined)
                        report_mismatch("undefined_flags", 64'(got.undefined),
                                        64'(want.undefined));
                    if (got.overflow !== want.overflow)
                        report_mismatch("counter_overflow", 64'(got.overflow),
                                        64'(want.overflow));
                    if (pad !== '0)
                        report_mismatch("tdata padding", 64'(pad), 64'd0);
                end
                checked++;
            end
            // observation transaction: classify and accumulate
            if (i_obs_valid && i_obs_ready) begin
                prob     = i_obs_data[PB-1:0];
                observed = i_obs_data[wcm_pkg::IN_OBS_POS];
                weight   = i_obs_data[wcm_pkg::IN_WEIGHT_LSB +: WB];
                positive = prob > thresh_reg;
                if (observed && positive)
                    tp_weight = add_weight(tp_weight, weight);
                else if (observed)
                    fn_weight = add_weight(fn_weight, weight);
                else if (positive)
                    fp_weight = add_weight(fp_weight, weight);
                else
                    tn_weight = add_weight(tn_weight, weight);
                if (item_total != ITEM_TOP)
                    item_total++;
                if (i_obs_last) begin
                    metrics_due.push_back(pass_metrics());
                    clear_pass();
                end
            end
            // threshold write
            if (i_cfg_valid && i_cfg_ready)
                thresh_reg = i_cfg_data;
        end
        o_pending    <= metrics_due.size();
        o_mismatches <= mismatches;
        o_checked    <= checked;
    end

endmodule

>>> test/testbench.sv
`timescale 1ns / 1ps
// ============================================================================
// testbench
// Drives observation passes into weighted_confusion_metrics under random
// threshold settings and random back-pressure; a checker beside the block
// predicts each pass result and counts mismatches.
// ============================================================================
module testbench;

    localparam int PB              = wcm_pkg::PROB_BITS;
    localparam int WB              = wcm_pkg::WEIGHT_BITS;
    localparam int IN_W            = wcm_pkg::IN_TDATA_BITS;
    localparam int OUT_W           = wcm_pkg::OUT_TDATA_BITS;
    localparam int CYCLE_LIMIT     = 2_000_000;
    // Result latency after a last item, with some margin
    localparam int SETTLE_CYCLES   = 5 * (wcm_pkg::COUNT_BITS_DEF + PB + 3) + 24;
    localparam int NUM_PHASES      = 6;
    localparam int HOLD_PHASE      = 3;
    localparam int HOLD_CYCLES     = 1500;
    localparam int ITEMS_PER_PHASE = 180;

    // Clock and reset
    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    // Threshold channel
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [PB-1:0]         i_cfg_data  = '0;

    // Observation stream
    logic                      s_axis_tvalid = 1'b0;
    logic                      s_axis_tready;
    logic [IN_W-1:0]           s_axis_tdata  = '0;   // probability, observed, weight
    logic                      s_axis_tlast  = 1'b0;

    // Result stream
    logic                      m_axis_tvalid;
    logic                      m_axis_tready = 1'b0;
    logic [OUT_W-1:0]          m_axis_tdata;  // sens, spec, ppv, npv, miss, flags, ovf

    int mismatches;
    int results_pending;
    int results_checked;

    int unsigned          cycle_count  = 0;
    logic [PB-1:0]        thr_now      = wcm_pkg::THRESH_RESET;
    bit                   in_idle_on   = 1'b1;
    bit                   out_idle_on  = 1'b1;
    logic                 hold_request = 1'b0;
    int                   items_sent   = 0;
    int                   passes_sent  = 0;
    int                   thresholds   = 1;

    always begin
        #6;
        i_clk = 1'b1;
        #6;
        i_clk = 1'b0;
    end

    weighted_confusion_metrics dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    wcm_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data),
        .i_obs_valid  (s_axis_tvalid),
        .i_obs_ready  (s_axis_tready),
        .i_obs_data   (s_axis_tdata),
        .i_obs_last   (s_axis_tlast),
        .i_res_valid  (m_axis_tvalid),
        .i_res_ready  (m_axis_tready),
        .i_res_data   (m_axis_tdata),
        .o_mismatches (mismatches),
        .o_pending    (results_pending),
        .o_checked    (results_checked)
    );

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("run stopped after %0d cycles with %0d results outstanding",
                     CYCLE_LIMIT, results_pending);
            $display("FAILURE");
            $finish;
        end
    end

    // Mostly uniform, some extremes, some hugging the threshold
    function automatic logic [PB-1:0] rand_prob();
        int near;
        case ($urandom_range(0, 9))
            0: return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
            1, 2, 3: begin
                near = int'(thr_now) + int'($urandom_range(0, 4)) - 2;
                if (near < 0)
                    near = 0;
                if (near > 65535)
                    near = 65535;
                return PB'(near);
            end
            default: return PB'($urandom_range(0, 65535));
        endcase
    endfunction

    // Small weights dominate so the miss rate stays mostly below its top
    function automatic logic [WB-1:0] rand_weight();
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: return WB'($urandom_range(0, 15));
            5, 6, 7:       return WB'($urandom_range(0, 1023));
            8:             return WB'($urandom_range(0, 65535));
            default:       return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
        endcase
    endfunction

    // One observation transaction, after a random gap
    task automatic send_obs(input logic [PB-1:0] prob, input logic observed,
                            input logic [WB-1:0] weight, input logic last);
        int gap;
        gap = in_idle_on ? $urandom_range(0, 8) : 0;
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= IN_W'({weight, observed, prob});
        s_axis_tlast  <= last;
        do @(posedge i_clk); while (!s_axis_tready);
        items_sent++;
        if (last)
            passes_sent++;
        if ($urandom_range(0, 39) == 0)
            in_idle_on = !in_idle_on;
    endtask

    task automatic random_pass(input int len);
        int   obs_mode;
        logic observed;
        // some passes hold one class only, to empty denominators
        obs_mode = $urandom_range(0, 5);
        for (int k = 0; k < len; k++) begin
            case (obs_mode)
                0:       observed = 1'b0;
                1:       observed = 1'b1;
                default: observed = 1'($urandom_range(0, 1));
            endcase
            send_obs(rand_prob(), observed, rand_weight(), k == len - 1);
        end
    endtask

    // Idle the input and let every pending result come out
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (results_pending != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_threshold(input logic [PB-1:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        thr_now = value;
        thresholds++;
    endtask

    // Result side: random stalls, and one long hold on request
    initial begin
        int gap;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if (hold_request) begin
                hold_request  <= 1'b0;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else begin
                gap = out_idle_on ? $urandom_range(0, 8) : 0;
                if (gap != 0) begin
                    m_axis_tready <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
            if ($urandom_range(0, 5) == 0)
                out_idle_on = !out_idle_on;
        end
    end

    // Stimulus and verdict
    initial begin
        logic [PB-1:0]        next_thr;
        int                   phase_items;
        int                   len;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed passes at the reset threshold
        send_obs(16'hFFFF, 1'b1, 16'hFFFF, 1'b1);          // lone true positive
        send_obs(16'h0000, 1'b0, 16'h0000, 1'b1);          // zero weight: all ratios undefined
        send_obs(wcm_pkg::THRESH_RESET, 1'b1, 16'd1, 1'b0); // equal to threshold is negative
        send_obs(wcm_pkg::THRESH_RESET + 1'b1, 1'b0, 16'd2, 1'b0);
        send_obs(wcm_pkg::THRESH_RESET + 1'b1, 1'b1, 16'd3, 1'b0);
        send_obs(wcm_pkg::THRESH_RESET - 1'b1, 1'b0, 16'd5, 1'b1);
        send_obs(16'h0000, 1'b1, 16'd255, 1'b1);           // miss rate just below its top
        send_obs(16'h0000, 1'b1, 16'd256, 1'b1);           // miss rate one step past its top
        send_obs(16'hFFFF, 1'b0, 16'hFFFF, 1'b1);          // heavy false positive
        send_obs(16'd1000, 1'b0, 16'd0, 1'b0);
        send_obs(16'd40000, 1'b1, 16'd7, 1'b0);
        send_obs(16'd20000, 1'b0, 16'd0, 1'b1);

        // Random phases, each under its own threshold
        for (int p = 0; p < NUM_PHASES; p++) begin
            wait_drained();
            case (p)
                0:       next_thr = '0;
                1:       next_thr = '1;
                NUM_PHASES - 1: next_thr = wcm_pkg::THRESH_RESET;
                default: next_thr = PB'($urandom_range(1, 65534));
            endcase
            write_threshold(next_thr);
            if (p == HOLD_PHASE)
                hold_request <= 1'b1;
            // probe both sides of the threshold
            send_obs(thr_now, 1'b1, rand_weight(), 1'b0);
            send_obs((thr_now == '1) ? thr_now : thr_now + 1'b1, 1'($urandom_range(0, 1)),
                     rand_weight(), 1'b1);
            phase_items = 0;
            while (phase_items < ITEMS_PER_PHASE) begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40)
                                                  : $urandom_range(1, 12);
                random_pass(len);
                phase_items += len;
            end
        end
        wait_drained();

        $display("covered %0d observations in %0d passes under %0d threshold settings,",
                 items_sent, passes_sent, thresholds);
        $display("including both threshold extremes and a clamped miss rate; %0d results",
                 results_checked);
        if (mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("%0d field mismatches", mismatches);
            $display("FAILURE");
        end
        $finish;
    end

endmodule

>>> sim.f
design/wcm_pkg.sv
design/wcm_accum.sv
design/wcm_div.sv
design/weighted_confusion_metrics.sv
test/wcm_checker.sv
test/testbench.sv
